### sv/segment_tree_range_sum_defines.svh
// assertion macros shared by the segment tree block
`ifndef SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/segtree_pkg.sv
`timescale 1ns / 1ps

package segtree_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int VALUE_BITS    = 16;
   localparam int STORE_DEPTH   = 2 * MAX_POSITIONS - 1;
   localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
   localparam int POS_BITS      = $clog2(MAX_POSITIONS);
   localparam int CNT_BITS      = POS_BITS + 1;
   localparam int SUM_BITS      = 26;
   localparam int AMOUNT_BITS   = 16;
   localparam int STACK_DEPTH   = 16;
   localparam int SP_BITS       = $clog2(STACK_DEPTH);

   localparam logic [VALUE_BITS-1:0] ELEM_MAX = '1;

   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_TAKE = 2'd1;
   localparam logic [1:0] CMD_ADD  = 2'd2;
   localparam logic [1:0] CMD_SUM  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   typedef struct packed {
      logic [1:0]             command;
      logic [POS_BITS-1:0]    index;
      logic [AMOUNT_BITS-1:0] amount;
      logic [POS_BITS-1:0]    range_end;
   } req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] result_value;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [SUM_BITS-1:0]  wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] k;
      logic [POS_BITS-1:0]  lo;
      logic [POS_BITS-1:0]  hi;
   } node_type;

endpackage

### sv/segtree_store.sv
`timescale 1ns / 1ps

module segtree_store (
   input  logic                             clock,
   input  segtree_pkg::mem_req_type         mem_req,
   output logic [segtree_pkg::SUM_BITS-1:0] rd_data
);

   logic [segtree_pkg::SUM_BITS-1:0] mem [segtree_pkg::STORE_DEPTH];
   logic [segtree_pkg::SUM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/segtree_ctrl.sv
`timescale 1ns / 1ps
`include "segment_tree_range_sum_defines.svh"

module segtree_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear_start,
   input  logic                             start,
   input  segtree_pkg::req_type             req,
   input  logic [segtree_pkg::CNT_BITS-1:0] positions,
   input  logic [segtree_pkg::SUM_BITS-1:0] rd_data,
   input  logic                             out_take,
   output logic                             idle,
   output logic                             out_valid,
   output segtree_pkg::rsp_type             out_rsp,
   output segtree_pkg::mem_req_type         mem_req
);

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_DESC    = 9'b000000100,
      S_LEAF    = 9'b000001000,
      S_DELTA   = 9'b000010000,
      S_UP      = 9'b000100000,
      S_SUM     = 9'b001000000,
      S_SUM_END = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type                                state_ff, state_in;
   logic [segtree_pkg::ADDR_BITS-1:0]        clr_ff, clr_in;
   segtree_pkg::req_type                     req_ff, req_in;
   segtree_pkg::node_type                    cur_ff, cur_in;
   logic [segtree_pkg::SUM_BITS-1:0]         acc_ff, acc_in;
   logic [segtree_pkg::SUM_BITS-1:0]         delta_ff, delta_in;
   logic [segtree_pkg::VALUE_BITS-1:0]       new_ff, new_in;
   logic [1:0]                               status_ff, status_in;
   logic [segtree_pkg::SP_BITS-1:0]          sp_ff, sp_in;
   logic                                     pend_ff, pend_in;
   segtree_pkg::node_type                    stk_ff [segtree_pkg::STACK_DEPTH];

   logic                                     push;
   segtree_pkg::node_type                    push_node;
   segtree_pkg::node_type                    top_node;

   logic [segtree_pkg::SUM_BITS-1:0]         alu_a, alu_b, alu_sum;
   logic                                     alu_cin;

   logic [segtree_pkg::POS_BITS-1:0]         last;
   logic                                     idx_bad, end_bad;
   logic [segtree_pkg::POS_BITS:0]           mid_sum;
   logic [segtree_pkg::POS_BITS-1:0]         mid;
   logic [segtree_pkg::ADDR_BITS-1:0]        k_left, k_right, k_par;
   logic                                     covered, disjoint;

   assign last    = segtree_pkg::POS_BITS'(positions - segtree_pkg::CNT_BITS'(1));
   assign idx_bad = segtree_pkg::CNT_BITS'(req.index) >= positions;
   assign end_bad = segtree_pkg::CNT_BITS'(req.range_end) >= positions;
   assign mid_sum = {1'b0, cur_ff.lo} + {1'b0, cur_ff.hi};
   assign mid     = mid_sum[segtree_pkg::POS_BITS:1];
   assign k_left  = {cur_ff.k[segtree_pkg::ADDR_BITS-2:0], 1'b1};
   assign k_right = k_left + segtree_pkg::ADDR_BITS'(1);
   assign k_par   = (cur_ff.k - segtree_pkg::ADDR_BITS'(1)) >> 1;
   assign covered  = (req_ff.index <= cur_ff.lo) && (req_ff.range_end >= cur_ff.hi);
   assign disjoint = (req_ff.index > cur_ff.hi) || (req_ff.range_end < cur_ff.lo);
   assign top_node = stk_ff[sp_ff - segtree_pkg::SP_BITS'(1)];

   // shared adder operand select
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = rd_data;
      alu_cin = 1'b0;
      case (state_ff)
         S_LEAF: begin
            alu_a = rd_data;
            alu_b = segtree_pkg::SUM_BITS'(req_ff.amount);
         end
         S_DELTA: begin
            // new minus old, modulo the node width
            alu_a   = segtree_pkg::SUM_BITS'(new_ff);
            alu_b   = ~acc_ff;
            alu_cin = 1'b1;
         end
         S_UP: begin
            alu_a = rd_data;
            alu_b = delta_ff;
         end
         default: begin
            alu_a = acc_ff;
            alu_b = rd_data;
         end
      endcase
   end

   assign alu_sum = alu_a + alu_b + segtree_pkg::SUM_BITS'(alu_cin);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      req_in    = req_ff;
      cur_in    = cur_ff;
      acc_in    = acc_ff;
      delta_in  = delta_ff;
      new_in    = new_ff;
      status_in = status_ff;
      sp_in     = sp_ff;
      pend_in   = 1'b0;
      push      = 1'b0;
      push_node = '{k: k_right, lo: mid + segtree_pkg::POS_BITS'(1), hi: cur_ff.hi};
      mem_req   = '0;
      idle      = 1'b0;
      out_valid = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = '0;
            clr_in          = clr_ff + segtree_pkg::ADDR_BITS'(1);
            if (clr_ff == segtree_pkg::ADDR_BITS'(segtree_pkg::STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               req_in    = req;
               acc_in    = '0;
               status_in = segtree_pkg::ST_OK;
               cur_in    = '{k: '0, lo: '0, hi: last};
               sp_in     = '0;
               if (req.command == segtree_pkg::CMD_SUM) begin
                  if (idx_bad || end_bad) begin
                     status_in = segtree_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else if (req.index > req.range_end) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SUM;
                  end
               end else if (idx_bad) begin
                  status_in = segtree_pkg::ST_RANGE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DESC;
               end
            end
         end
         S_DESC: begin
            if (cur_ff.lo == cur_ff.hi) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cur_ff.k;
               state_in        = S_LEAF;
            end else if (req_ff.index <= mid) begin
               cur_in = '{k: k_left, lo: cur_ff.lo, hi: mid};
            end else begin
               cur_in = '{k: k_right, lo: mid + segtree_pkg::POS_BITS'(1), hi: cur_ff.hi};
            end
         end
         S_LEAF: begin
            // acc holds the old leaf value until the delta is formed
            acc_in = rd_data;
            case (req_ff.command)
               segtree_pkg::CMD_SET: begin
                  new_in = segtree_pkg::VALUE_BITS'(req_ff.amount);
               end
               segtree_pkg::CMD_ADD: begin
                  if (alu_sum[segtree_pkg::SUM_BITS-1:segtree_pkg::VALUE_BITS] != '0) begin
                     new_in    = segtree_pkg::ELEM_MAX;
                     status_in = segtree_pkg::ST_SAT;
                  end else begin
                     new_in = alu_sum[segtree_pkg::VALUE_BITS-1:0];
                  end
               end
               default: begin
                  new_in = '0;
               end
            endcase
            state_in = S_DELTA;
         end
         S_DELTA: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff.k;
            mem_req.wr_data = segtree_pkg::SUM_BITS'(new_ff);
            delta_in        = alu_sum;
            if (req_ff.command != segtree_pkg::CMD_TAKE) begin
               acc_in = '0;
            end
            if (cur_ff.k == '0) begin
               state_in = S_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = k_par;
               cur_in.k        = k_par;
               state_in        = S_UP;
            end
         end
         S_UP: begin
            // write this ancestor and fetch the next one up in the same cycle
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff.k;
            mem_req.wr_data = alu_sum;
            if (cur_ff.k == '0) begin
               state_in = S_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = k_par;
               cur_in.k        = k_par;
            end
         end
         S_SUM: begin
            if (pend_ff) begin
               acc_in = alu_sum;
            end
            if (covered || disjoint) begin
               if (covered) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = cur_ff.k;
                  pend_in         = 1'b1;
               end
               if (sp_ff == '0) begin
                  state_in = S_SUM_END;
               end else begin
                  cur_in = top_node;
                  sp_in  = sp_ff - segtree_pkg::SP_BITS'(1);
               end
            end else begin
               // defer the right child, go on with the left
               push   = 1'b1;
               sp_in  = sp_ff + segtree_pkg::SP_BITS'(1);
               cur_in = '{k: k_left, lo: cur_ff.lo, hi: mid};
            end
         end
         S_SUM_END: begin
            if (pend_ff) begin
               acc_in = alu_sum;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            out_valid = 1'b1;
            if (out_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear_start) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      cur_ff    <= cur_in;
      acc_ff    <= acc_in;
      delta_ff  <= delta_in;
      new_ff    <= new_in;
      status_ff <= status_in;
      if (push) begin
         stk_ff[sp_ff] <= push_node;
      end
   end

   assign out_rsp.result_value = acc_ff;
   assign out_rsp.status       = status_ff;

   `ASSERT_IMPLIES(a_stack_room, clock, reset, push, sp_ff != '1)
   `ASSERT_IMPLIES(a_clear_zero, clock, reset, state_ff == S_CLEAR,
                   mem_req.wr_en && (mem_req.wr_data == '0))
   `ASSERT_IMPLIES(a_up_addr, clock, reset, state_ff == S_UP,
                   $past(mem_req.rd_en) && ($past(mem_req.rd_addr) == mem_req.wr_addr))
   `ASSERT_IMPLIES(a_pend_sum, clock, reset, pend_ff,
                   (state_ff == S_SUM) || (state_ff == S_SUM_END))
   `ASSERT_NEXT(a_start_busy, clock, reset, start && idle && !clear_start, !idle)

endmodule

### sv/segment_tree_range_sum.sv
`timescale 1ns / 1ps

// Segment tree over up to 1024 positions of 16-bit values, node sums kept in a
// 2047-entry single-port-write, single-port-read memory.
// req_ channel: one command word (set, take and zero, add with saturation, or
// inclusive range sum); rsp_ channel: one word per command with the value and a
// status code. csr_write_en/csr_write_data set the number of positions in use;
// a write zeroes every stored value.
// Timing: one tree level per cycle through a single memory read port and one
// shared adder. With L = ceil(log2(positions)), set/take/add go from accept
// to result by descending to the leaf, reading the leaf, forming the change,
// walking the ancestors back up and loading the rsp_ register.
// A range sum visits each tree node on the two range boundaries, about 4L
// nodes worst case. Bad indexes and reversed ranges skip the tree and go
// straight to the result.
// Reset and every csr write start a clearing pass over the 2047 entries
// with req_ready low. A result sits in the rsp_ output register; the block
// accepts the next word meanwhile, but holds its following result until that
// register is taken, so a stalled receiver eventually stalls req_ready.
module segment_tree_range_sum (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  segtree_pkg::req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output segtree_pkg::rsp_type             rsp_data,
   input  logic                             csr_write_en,
   input  logic [segtree_pkg::CNT_BITS-1:0] csr_write_data
);

   logic [segtree_pkg::CNT_BITS-1:0] positions_ff, positions_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   segtree_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                             idle;
   logic                             start;
   logic                             out_valid;
   logic                             out_take;
   segtree_pkg::rsp_type             out_rsp;
   segtree_pkg::mem_req_type         mem_req;
   logic [segtree_pkg::SUM_BITS-1:0] rd_data;

   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign out_take  = out_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      positions_in = positions_ff;
      if (csr_write_en) begin
         if (csr_write_data == '0) begin
            positions_in = segtree_pkg::CNT_BITS'(1);
         end else if (csr_write_data > segtree_pkg::CNT_BITS'(segtree_pkg::MAX_POSITIONS)) begin
            positions_in = segtree_pkg::CNT_BITS'(segtree_pkg::MAX_POSITIONS);
         end else begin
            positions_in = csr_write_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         positions_ff <= segtree_pkg::CNT_BITS'(segtree_pkg::MAX_POSITIONS);
         rsp_valid_ff <= 1'b0;
      end else begin
         positions_ff <= positions_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   segtree_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .clear_start (csr_write_en),
      .start       (start),
      .req         (req_data),
      .positions   (positions_ff),
      .rd_data     (rd_data),
      .out_take    (out_take),
      .idle        (idle),
      .out_valid   (out_valid),
      .out_rsp     (out_rsp),
      .mem_req     (mem_req)
   );

   segtree_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

### verif/segment_tree_range_sum_checker.sv
`timescale 1ns / 1ps

module segtree_sum_checker
   import segtree_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_data,
   input  logic                csr_write_en,
   input  logic [CNT_BITS-1:0] csr_write_data,
   output int                  mismatch_count,
   output int                  replies_outstanding
);

   // flat copy of the leaf values; a node sum is just the total over its span
   logic [VALUE_BITS-1:0] position_value [MAX_POSITIONS];
   int                    active_count;
   rsp_type               replies_due [$];
   int                    reply_seq;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] reply %0d: %s got %0h want %0h", $time, reply_seq, what, got, want);
      mismatch_count++;
   endtask

   function automatic rsp_type predict_reply(input req_type w);
      rsp_type             r;
      logic [VALUE_BITS:0] grown;
      r = '0;
      r.status = ST_OK;
      if (w.command == CMD_SUM) begin
         // bound check wins over the reversed-range case
         if (w.index >= active_count || w.range_end >= active_count) begin
            r.status = ST_RANGE;
         end else begin
            for (int p = int'(w.index); p <= w.range_end; p++) begin
               r.result_value += SUM_BITS'(position_value[p]);
            end
         end
      end else if (w.index >= active_count) begin
         r.status = ST_RANGE;
      end else begin
         case (w.command)
            CMD_SET: begin
               position_value[w.index] = w.amount[VALUE_BITS-1:0];
            end
            CMD_TAKE: begin
               r.result_value = SUM_BITS'(position_value[w.index]);
               position_value[w.index] = '0;
            end
            default: begin
               grown = {1'b0, position_value[w.index]} + {1'b0, w.amount[VALUE_BITS-1:0]};
               if (grown > {1'b0, ELEM_MAX}) begin
                  grown = {1'b0, ELEM_MAX};
                  r.status = ST_SAT;
               end
               position_value[w.index] = grown[VALUE_BITS-1:0];
            end
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      count_cfg;
      if (reset) begin
         foreach (position_value[p]) position_value[p] = '0;
         active_count = MAX_POSITIONS;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("word with nothing pending", 32'(rsp_data), 0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  report_mismatch("result_value", 32'(rsp_data.result_value),
                                  32'(want.result_value));
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               end
            end
            reply_seq++;
         end
         if (req_valid && req_ready) begin
            replies_due.push_back(predict_reply(req_data));
         end
         if (csr_write_en) begin
            count_cfg = int'(csr_write_data);
            if (count_cfg == 0) count_cfg = 1;
            if (count_cfg > MAX_POSITIONS) count_cfg = MAX_POSITIONS;
            active_count = count_cfg;
            // any write wipes the tree
            foreach (position_value[p]) position_value[p] = '0;
         end
      end
      replies_outstanding <= replies_due.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import segtree_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 10000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_WORDS  = 80;
   localparam int PHASE_COUNT  = 12;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   req_type             req_data       = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_en   = 1'b0;
   logic [CNT_BITS-1:0] csr_write_data = '0;

   int mismatch_count;
   int replies_outstanding;
   int idle_cycles;
   int positions    = MAX_POSITIONS;
   bit no_idle      = 1'b0;
   bit hold_request = 1'b0;

   segment_tree_range_sum uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   segtree_sum_checker reply_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .replies_outstanding (replies_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5 && positions < MAX_POSITIONS) return $urandom_range(positions, MAX_POSITIONS - 1);
      if (r < 12) return 0;
      if (r < 20) return positions - 1;
      return $urandom_range(0, positions - 1);
   endfunction

   function automatic int pick_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 25) return int'(ELEM_MAX);
      if (r < 40) return $urandom_range(0, 15);
      return $urandom_range(0, ELEM_MAX);
   endfunction

   // valid stays up after acceptance when the next word follows at once
   task automatic send_word(input logic [1:0] cmd, input int idx, input int amt,
                            input int last_pos);
      req_type w;
      int      gap;
      w.command   = cmd;
      w.index     = idx[POS_BITS-1:0];
      w.amount    = amt[AMOUNT_BITS-1:0];
      w.range_end = last_pos[POS_BITS-1:0];
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_positions(input int value);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value[CNT_BITS-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      positions = (value == 0) ? 1 : (value > MAX_POSITIONS) ? MAX_POSITIONS : value;
   endtask

   task automatic random_word();
      int r;
      int a;
      int b;
      r = $urandom_range(0, 99);
      a = pick_pos();
      b = pick_pos();
      if (r < 28) begin
         send_word(CMD_SET, a, pick_amount(), $urandom_range(0, 1023));
      end else if (r < 42) begin
         send_word(CMD_TAKE, a, $urandom_range(0, ELEM_MAX), $urandom_range(0, 1023));
      end else if (r < 62) begin
         send_word(CMD_ADD, a, pick_amount(), $urandom_range(0, 1023));
      end else if (r < 92) begin
         // mostly ordered ranges, some reversed on purpose
         if (($urandom_range(0, 4) == 0) == (a <= b)) begin
            send_word(CMD_SUM, b, $urandom_range(0, ELEM_MAX), a);
         end else begin
            send_word(CMD_SUM, a, $urandom_range(0, ELEM_MAX), b);
         end
      end else begin
         send_word(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                   $urandom_range(0, ELEM_MAX), $urandom_range(0, 1023));
      end
   endtask

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int run;
      int stall;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run = $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("segment_tree_range_sum test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int setting;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full-size tree straight out of reset
      send_word(CMD_SET, 0, int'(ELEM_MAX), 1023);
      send_word(CMD_SET, 1023, int'(ELEM_MAX), 0);
      send_word(CMD_SET, 512, 1, 0);
      send_word(CMD_SUM, 0, 0, 1023);
      send_word(CMD_ADD, 0, 1, 0);
      send_word(CMD_ADD, 512, ELEM_MAX - 1, 0);
      send_word(CMD_ADD, 512, 0, 0);
      send_word(CMD_ADD, 1023, int'(ELEM_MAX), 0);
      send_word(CMD_TAKE, 0, 0, 0);
      send_word(CMD_TAKE, 0, 0, 0);
      send_word(CMD_SUM, 1023, 0, 0);
      send_word(CMD_SUM, 512, 0, 512);
      send_word(CMD_SUM, 0, 0, 511);
      send_word(CMD_SET, 341, 'h2AAA, 682);
      send_word(CMD_SET, 682, 'h5555, 341);
      send_word(CMD_SUM, 341, 0, 682);

      // small tree: bound checks and the reversed range
      write_positions(5);
      send_word(CMD_SET, 4, 9, 0);
      send_word(CMD_SET, 5, 1, 0);
      send_word(CMD_TAKE, 7, 0, 0);
      send_word(CMD_ADD, 1023, 1, 0);
      send_word(CMD_SUM, 0, 0, 5);
      send_word(CMD_SUM, 5, 0, 0);
      send_word(CMD_SUM, 0, 0, 4);
      send_word(CMD_SUM, 4, 0, 3);
      write_positions(5);
      send_word(CMD_SUM, 0, 0, 4);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       setting = 0;
            1:       setting = 2047;
            2:       setting = 1025;
            3:       setting = 2;
            4:       setting = 3;
            5:       setting = 7;
            6:       setting = $urandom_range(8, 64);
            7:       setting = 513;
            8:       setting = 1000;
            9:       setting = $urandom_range(1, MAX_POSITIONS);
            10:      setting = MAX_POSITIONS;
            default: setting = $urandom_range(0, 2047);
         endcase
         write_positions(setting);
         no_idle = ($urandom_range(0, 3) == 0);
         if (ph == 3 || ph == 8) hold_request = 1'b1;
         repeat (PHASE_WORDS) random_word();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("segment_tree_range_sum test passed");
      end else begin
         $display("segment_tree_range_sum test failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/segtree_pkg.sv
sv/segtree_store.sv
sv/segtree_ctrl.sv
sv/segment_tree_range_sum.sv
verif/segment_tree_range_sum_checker.sv
verif/tb.sv
